@@ rtl/core/cor_pkg.sv @@
// ---------------------------------------------------------------------------
// Circle outline rasterizer package
// Shared widths, limits and result codes for the outline walk.
// ---------------------------------------------------------------------------
package cor_pkg;

   localparam int CENTER_W         = 10;
   localparam int RADIUS_Q_W       = 9;
   localparam int POINT_W          = 12;
   localparam int RADIUS_FRAC_BITS = 4;
   localparam int MAX_RADIUS       = 31;
   localparam int WALK_W           = 6;
   localparam int SQ_W             = 10;
   localparam int DIST_W           = 12;
   localparam int PRODUCT_W        = 2 * RADIUS_Q_W;

   localparam logic [PRODUCT_W-1:0] SQ_MAX =
      PRODUCT_W'((MAX_RADIUS + 1) * (MAX_RADIUS + 1) - 1);
   localparam logic [RADIUS_Q_W-1:0] R_MAX = RADIUS_Q_W'(MAX_RADIUS);

   localparam logic KIND_OUTLINE = 1'b0;
   localparam logic KIND_AIM     = 1'b1;

endpackage

@@ rtl/core/cor_squarer.sv @@
// ---------------------------------------------------------------------------
// Circle outline rasterizer squarer
// Shared registered squarer used for both the squared radius and the
// initial walk distance.
// ---------------------------------------------------------------------------
module cor_squarer (
   input  logic                               clock,
   input  logic [cor_pkg::RADIUS_Q_W-1:0]     operand,
   output logic [cor_pkg::PRODUCT_W-1:0]      product_ff
);

   logic [cor_pkg::PRODUCT_W-1:0] product_in;

   assign product_in = cor_pkg::PRODUCT_W'(operand) * cor_pkg::PRODUCT_W'(operand);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

@@ rtl/core/circle_outline_rasterizer.sv @@
// ---------------------------------------------------------------------------
// Circle outline rasterizer
// Flow: a request passes ST_LOAD_S, ST_LOAD_R and ST_LOAD_D; the walk then
// sends N outline results (at most 2r + 1) and one aim result, one step per
// cycle while the result register is free. One request is handled at a time.
// Reset: synchronous; the block returns idle with no result pending.
// ---------------------------------------------------------------------------
module circle_outline_rasterizer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cor_pkg::CENTER_W-1:0]          req_center_x,
   input  logic [cor_pkg::CENTER_W-1:0]          req_center_y,
   input  logic [cor_pkg::RADIUS_Q_W-1:0]        req_radius_q,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_kind,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_pos_x,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_pos_y,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_neg_x,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_neg_y,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_pos_x,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_pos_y,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_neg_x,
   output logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_neg_y,
   output logic                                  rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD_S = 6'b000010,
      ST_LOAD_R = 6'b000100,
      ST_LOAD_D = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_AIM    = 6'b100000
   } state_type;

   localparam int PW = cor_pkg::POINT_W;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [cor_pkg::CENTER_W-1:0]   center_x_ff, center_x_in;
   logic [cor_pkg::CENTER_W-1:0]   center_y_ff, center_y_in;
   logic [cor_pkg::RADIUS_Q_W-1:0] radius_q_ff, radius_q_in;
   logic [cor_pkg::WALK_W-1:0]     walk_x_ff, walk_x_in;
   logic [cor_pkg::WALK_W-1:0]     walk_y_ff, walk_y_in;
   logic [cor_pkg::SQ_W-1:0]       radius_sq_ff, radius_sq_in;
   logic [cor_pkg::DIST_W-1:0]     dist_ff, dist_in;

   logic                           kind_ff, kind_in;
   logic                           last_ff, last_in;
   logic [PW-1:0]                  ppx_ff, ppx_in, ppy_ff, ppy_in;
   logic [PW-1:0]                  pnx_ff, pnx_in, pny_ff, pny_in;
   logic [PW-1:0]                  npx_ff, npx_in, npy_ff, npy_in;
   logic [PW-1:0]                  nnx_ff, nnx_in, nny_ff, nny_in;

   logic [cor_pkg::RADIUS_Q_W-1:0] sq_operand;
   logic [cor_pkg::PRODUCT_W-1:0]  sq_product;
   logic [cor_pkg::PRODUCT_W-1:0]  sq_scaled;
   logic [cor_pkg::RADIUS_Q_W-1:0] radius_whole;
   logic                           accept;
   logic                           emit;
   logic                           step_x;
   logic [PW-1:0]                  cx_ext, cy_ext, dx_ext, dy_ext;

   cor_squarer u_squarer (
      .clock      (clock),
      .operand    (sq_operand),
      .product_ff (sq_product)
   );

   assign accept       = req_valid && req_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign emit         = ((state_ff == ST_WALK) || (state_ff == ST_AIM)) &&
                         (!rsp_valid_ff || rsp_ready);
   assign step_x       = (dist_ff <= cor_pkg::DIST_W'(radius_sq_ff));
   assign radius_whole = req_radius_q >> cor_pkg::RADIUS_FRAC_BITS;
   assign sq_operand   = (state_ff == ST_LOAD_S) ? radius_q_ff :
                         cor_pkg::RADIUS_Q_W'(walk_y_ff);
   assign sq_scaled    = sq_product >> (2 * cor_pkg::RADIUS_FRAC_BITS);

   assign cx_ext = PW'(center_x_ff);
   assign cy_ext = PW'(center_y_ff);
   assign dx_ext = (state_ff == ST_AIM) ? '0 : PW'(walk_x_ff);
   assign dy_ext = (state_ff == ST_AIM) ? '0 : PW'(walk_y_ff);

   always_comb begin
      state_in     = state_ff;
      center_x_in  = center_x_ff;
      center_y_in  = center_y_ff;
      radius_q_in  = radius_q_ff;
      walk_x_in    = walk_x_ff;
      walk_y_in    = walk_y_ff;
      radius_sq_in = radius_sq_ff;
      dist_in      = dist_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               center_x_in = req_center_x;
               center_y_in = req_center_y;
               radius_q_in = req_radius_q;
               walk_x_in   = '0;
               walk_y_in   = (radius_whole > cor_pkg::R_MAX) ?
                             cor_pkg::WALK_W'(cor_pkg::MAX_RADIUS) :
                             radius_whole[cor_pkg::WALK_W-1:0];
               state_in    = ST_LOAD_S;
            end
         end
         ST_LOAD_S: begin
            state_in = ST_LOAD_R;
         end
         ST_LOAD_R: begin
            radius_sq_in = (sq_scaled > cor_pkg::SQ_MAX) ?
                           cor_pkg::SQ_MAX[cor_pkg::SQ_W-1:0] :
                           sq_scaled[cor_pkg::SQ_W-1:0];
            state_in     = ST_LOAD_D;
         end
         ST_LOAD_D: begin
            dist_in  = sq_product[cor_pkg::DIST_W-1:0] + cor_pkg::DIST_W'(1);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (emit) begin
               if (step_x) begin
                  walk_x_in = walk_x_ff + cor_pkg::WALK_W'(1);
                  dist_in   = dist_ff + cor_pkg::DIST_W'({walk_x_ff, 1'b0}) +
                              cor_pkg::DIST_W'(3);
               end else if (walk_y_ff == '0) begin
                  state_in = ST_AIM;
               end else begin
                  walk_y_in = walk_y_ff - cor_pkg::WALK_W'(1);
                  dist_in   = dist_ff - cor_pkg::DIST_W'({walk_y_ff, 1'b0}) +
                              cor_pkg::DIST_W'(1);
               end
            end
         end
         ST_AIM: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      last_in      = last_ff;
      ppx_in       = ppx_ff;
      ppy_in       = ppy_ff;
      pnx_in       = pnx_ff;
      pny_in       = pny_ff;
      npx_in       = npx_ff;
      npy_in       = npy_ff;
      nnx_in       = nnx_ff;
      nny_in       = nny_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = (state_ff == ST_AIM) ? cor_pkg::KIND_AIM : cor_pkg::KIND_OUTLINE;
         last_in      = (state_ff == ST_AIM);
         ppx_in       = cx_ext + dx_ext;
         ppy_in       = cy_ext + dy_ext;
         pnx_in       = cx_ext + dx_ext;
         pny_in       = cy_ext - dy_ext;
         npx_in       = cx_ext - dx_ext;
         npy_in       = cy_ext + dy_ext;
         nnx_in       = cx_ext - dx_ext;
         nny_in       = cy_ext - dy_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      center_x_ff  <= center_x_in;
      center_y_ff  <= center_y_in;
      radius_q_ff  <= radius_q_in;
      walk_x_ff    <= walk_x_in;
      walk_y_ff    <= walk_y_in;
      radius_sq_ff <= radius_sq_in;
      dist_ff      <= dist_in;
      kind_ff      <= kind_in;
      last_ff      <= last_in;
      ppx_ff       <= ppx_in;
      ppy_ff       <= ppy_in;
      pnx_ff       <= pnx_in;
      pny_ff       <= pny_in;
      npx_ff       <= npx_in;
      npy_ff       <= npy_in;
      nnx_ff       <= nnx_in;
      nny_ff       <= nny_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_last      = last_ff;
   assign rsp_pos_pos_x = ppx_ff;
   assign rsp_pos_pos_y = ppy_ff;
   assign rsp_pos_neg_x = pnx_ff;
   assign rsp_pos_neg_y = pny_ff;
   assign rsp_neg_pos_x = npx_ff;
   assign rsp_neg_pos_y = npy_ff;
   assign rsp_neg_neg_x = nnx_ff;
   assign rsp_neg_neg_y = nny_ff;

endmodule

@@ rtl/core/cor_checker.sv @@
// ---------------------------------------------------------------------------
// Circle outline rasterizer checker
// Port-level assertions on the request and result channels.
// ---------------------------------------------------------------------------
module cor_protocol_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_kind,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_pos_x,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_pos_y,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_neg_x,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_pos_neg_y,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_pos_x,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_pos_y,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_neg_x,
   input  logic signed [cor_pkg::POINT_W-1:0]    rsp_neg_neg_y,
   input  logic                                  rsp_last
);

   // A stalled result transaction holds its valid, kind, last, pos_pos_x and neg_neg_y.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_last) && $stable(rsp_pos_pos_x) && $stable(rsp_neg_neg_y))
      else $error("stalled result transaction changed");

   // The block takes one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a walk is starting");

   // The aim point closes the run and sits at the center.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == rsp_last) &&
      (!rsp_kind || (rsp_pos_pos_x == rsp_neg_neg_x && rsp_pos_pos_y == rsp_neg_neg_y)))
      else $error("aim point malformed");

   // Outline points are mirror images of one another.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pos_pos_x == rsp_pos_neg_x && rsp_neg_pos_x == rsp_neg_neg_x &&
      rsp_pos_pos_y == rsp_neg_pos_y && rsp_pos_neg_y == rsp_neg_neg_y)
      else $error("outline points not mirrored");

endmodule

bind circle_outline_rasterizer cor_protocol_checker u_cor_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_pos_pos_x (rsp_pos_pos_x),
   .rsp_pos_pos_y (rsp_pos_pos_y),
   .rsp_pos_neg_x (rsp_pos_neg_x),
   .rsp_pos_neg_y (rsp_pos_neg_y),
   .rsp_neg_pos_x (rsp_neg_pos_x),
   .rsp_neg_pos_y (rsp_neg_pos_y),
   .rsp_neg_neg_x (rsp_neg_neg_x),
   .rsp_neg_neg_y (rsp_neg_neg_y),
   .rsp_last      (rsp_last)
);
